/* sv/rrv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrv_pkg
// Shared types, register map and constants of the rounded rectangle vertex
// generator.
// ----------------------------------------------------------------------------
package rrv_pkg;

	localparam int COORD_W           = 16;
	localparam int TRIG_W            = 15;
	localparam int IDX_W             = 6;
	localparam int RAD_W             = 17;
	localparam int PTS_W             = 5;
	localparam int MAX_CORNER_POINTS = 16;
	localparam int ARC_W             = $clog2(MAX_CORNER_POINTS);
	localparam int COUNT_W           = IDX_W + 1;
	localparam int PADDR_W           = 4;
	localparam int PDATA_W           = 32;

	// Quarter turn in Q2.30 radians and the Q0.15 saturation limit.
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TRIG_SAT    = 64'd32767;

	localparam logic [COORD_W-1:0] RESET_WIDTH  = 16'd1600;
	localparam logic [COORD_W-1:0] RESET_HEIGHT = 16'd1600;
	localparam logic [RAD_W-1:0]   RESET_RADIUS = 17'd0;
	localparam logic [PTS_W-1:0]   RESET_POINTS = 5'd4;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RADIUS = 2'd2,
		REG_POINTS = 2'd3
	} reg_addr_t;

	typedef struct packed {
		logic [COORD_W-1:0] width;
		logic [COORD_W-1:0] height;
		logic [RAD_W-1:0]   radius;
		logic [PTS_W-1:0]   points;
	} cfg_t;

endpackage

/* sv/rounded_rect_vertex_gen_core.sv */
// A vertex is registered through stages s1 to s4 after its index transaction is
// accepted and is presented from s4, to be taken when the output is ready.
// Throughput: one transaction per cycle unless the output stalls; each of the four
// stages holds only while it is full and the next one holds, so bubbles close up.
// Reset clears all stage valid bits and restores the register defaults
// (1600 x 1600, radius 0, 4 points per corner); no memory needs clearing.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_rect_vertex_gen_core
// Generates one outline vertex of a rounded rectangle per requested index.
// ----------------------------------------------------------------------------
module rounded_rect_vertex_gen_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// Configuration port.
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rrv_pkg::PADDR_W-1:0]  paddr,
	input  logic [rrv_pkg::PDATA_W-1:0]  pwdata,
	output logic [rrv_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	// Index channel.
	input  logic                         point_valid,
	output logic                         point_ready,
	input  logic [rrv_pkg::IDX_W-1:0]    point_index,
	// Vertex channel.
	output logic                         vertex_valid,
	input  logic                         vertex_ready,
	output logic [rrv_pkg::COORD_W-1:0]  vertex_x,
	output logic [rrv_pkg::COORD_W-1:0]  vertex_y,
	output logic                         in_range,
	output logic                         is_final
);

	rrv_pkg::cfg_t cfg;

	rrv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage enables. A stage loads when it is empty or when the stage after
	// it is loading, so a stalled output only backs up as far as needed.
	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_s4;

	assign en4         = !v_s4 || vertex_ready;
	assign en3         = !v_s3 || en4;
	assign en2         = !v_s2 || en3;
	assign en1         = !v_s1 || en2;
	assign point_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= point_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: clamp the geometry and split the index into corner and arc
	// position.
	// ---------------------------------------------------------------------
	logic [rrv_pkg::COORD_W-1:0] dec_radius;
	logic [rrv_pkg::ARC_W-1:0]   dec_arc_last;
	logic [rrv_pkg::ARC_W-1:0]   dec_arc_pos;
	logic [1:0]                  dec_corner;
	logic                        dec_sharp;
	logic                        dec_in_range;
	logic                        dec_is_final;

	rrv_decode u_decode (
		.cfg         (cfg),
		.point_index (point_index),
		.radius      (dec_radius),
		.arc_last    (dec_arc_last),
		.arc_pos     (dec_arc_pos),
		.corner      (dec_corner),
		.sharp       (dec_sharp),
		.in_range    (dec_in_range),
		.is_final    (dec_is_final)
	);

	logic [rrv_pkg::COORD_W-1:0] r_s1;
	logic [rrv_pkg::ARC_W-1:0]   m_s1;
	logic [rrv_pkg::ARC_W-1:0]   j_s1;
	logic [1:0]                  corner_s1;
	logic                        sharp_s1;
	logic                        in_range_s1;
	logic                        final_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			r_s1        <= dec_radius;
			m_s1        <= dec_arc_last;
			j_s1        <= dec_arc_pos;
			corner_s1   <= dec_corner;
			sharp_s1    <= dec_sharp;
			in_range_s1 <= dec_in_range;
			final_s1    <= dec_is_final;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: look up sin and cos of the arc angle. Cosine is the sine of
	// the complementary arc position. Odd and even corners swap which value
	// drives x and which drives y.
	// ---------------------------------------------------------------------
	logic [rrv_pkg::TRIG_W-1:0] sin_val;
	logic [rrv_pkg::TRIG_W-1:0] cos_val;

	rrv_sin_rom u_sin_rom (
		.m     (m_s1),
		.ka    (j_s1),
		.kb    (m_s1 - j_s1),
		.sin_a (sin_val),
		.sin_b (cos_val)
	);

	logic [rrv_pkg::TRIG_W-1:0]  tx_s2;
	logic [rrv_pkg::TRIG_W-1:0]  ty_s2;
	logic [rrv_pkg::COORD_W-1:0] r_s2;
	logic [1:0]                  corner_s2;
	logic                        sharp_s2;
	logic                        in_range_s2;
	logic                        final_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			tx_s2       <= corner_s1[0] ? sin_val : cos_val;
			ty_s2       <= corner_s1[0] ? cos_val : sin_val;
			r_s2        <= r_s1;
			corner_s2   <= corner_s1;
			sharp_s2    <= sharp_s1;
			in_range_s2 <= in_range_s1;
			final_s2    <= final_s1;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: scale the trig values by the radius, rounding half up. The
	// offset never exceeds the radius, so it fits the coordinate width.
	// ---------------------------------------------------------------------
	logic [31:0] prod_x;
	logic [31:0] prod_y;

	assign prod_x = 32'(r_s2) * 32'(tx_s2) + 32'd16384;
	assign prod_y = 32'(r_s2) * 32'(ty_s2) + 32'd16384;

	logic [rrv_pkg::COORD_W-1:0] offx_s3;
	logic [rrv_pkg::COORD_W-1:0] offy_s3;
	logic [rrv_pkg::COORD_W-1:0] r_s3;
	logic [1:0]                  corner_s3;
	logic                        sharp_s3;
	logic                        in_range_s3;
	logic                        final_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			offx_s3     <= prod_x[30:15];
			offy_s3     <= prod_y[30:15];
			r_s3        <= r_s2;
			corner_s3   <= corner_s2;
			sharp_s3    <= sharp_s2;
			in_range_s3 <= in_range_s2;
			final_s3    <= final_s2;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 4: place the vertex around its corner center and saturate. The
	// left corners (0, 1) subtract from x = r; the right ones add to
	// x = W - r. The top corners (0, 3) subtract from y = r; the bottom ones
	// add to y = H - r. A sharp rectangle takes the plain corner points, and
	// an index past the vertex count reads as the origin.
	// ---------------------------------------------------------------------
	logic                        right3;
	logic                        bottom3;
	logic signed [17:0]          r_ext;
	logic signed [17:0]          sum_x;
	logic signed [17:0]          sum_y;
	logic [rrv_pkg::COORD_W-1:0] sat_x;
	logic [rrv_pkg::COORD_W-1:0] sat_y;
	logic [rrv_pkg::COORD_W-1:0] next_x;
	logic [rrv_pkg::COORD_W-1:0] next_y;

	assign right3  = corner_s3[1];
	assign bottom3 = corner_s3[1] ^ corner_s3[0];
	assign r_ext   = 18'(r_s3);

	always_comb begin
		if (right3) begin
			sum_x = 18'(cfg.width) - r_ext + 18'(offx_s3);
		end else begin
			sum_x = r_ext - 18'(offx_s3);
		end
		if (bottom3) begin
			sum_y = 18'(cfg.height) - r_ext + 18'(offy_s3);
		end else begin
			sum_y = r_ext - 18'(offy_s3);
		end

		if (sum_x < 0) begin
			sat_x = '0;
		end else if (sum_x > 18'sd65535) begin
			sat_x = '1;
		end else begin
			sat_x = sum_x[rrv_pkg::COORD_W-1:0];
		end
		if (sum_y < 0) begin
			sat_y = '0;
		end else if (sum_y > 18'sd65535) begin
			sat_y = '1;
		end else begin
			sat_y = sum_y[rrv_pkg::COORD_W-1:0];
		end

		if (!in_range_s3) begin
			next_x = '0;
			next_y = '0;
		end else if (sharp_s3) begin
			next_x = bottom3 ? cfg.width : '0;
			next_y = right3 ? cfg.height : '0;
		end else begin
			next_x = sat_x;
			next_y = sat_y;
		end
	end

	logic [rrv_pkg::COORD_W-1:0] x_s4;
	logic [rrv_pkg::COORD_W-1:0] y_s4;
	logic                        sharp_s4;
	logic                        in_range_s4;
	logic                        final_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			x_s4        <= next_x;
			y_s4        <= next_y;
			sharp_s4    <= sharp_s3;
			in_range_s4 <= in_range_s3;
			final_s4    <= final_s3;
		end
	end

	assign vertex_valid = v_s4;
	assign vertex_x     = x_s4;
	assign vertex_y     = y_s4;
	assign in_range     = in_range_s4;
	assign is_final     = final_s4;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_out_of_range_origin: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !in_range_s4 |-> vertex_x == '0 && vertex_y == '0)
		else $error("out-of-range vertex is not at the origin");

	a_final_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && final_s4 |-> in_range_s4)
		else $error("final vertex flagged outside the vertex count");

	a_sharp_corner: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && sharp_s4 && in_range_s4 |->
			(vertex_x == '0 || vertex_x == cfg.width) &&
			(vertex_y == '0 || vertex_y == cfg.height))
		else $error("sharp corner vertex off the rectangle corners");

	a_stall_keeps_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !en3 |=> v_s2 && $stable(tx_s2) && $stable(ty_s2))
		else $error("stage 2 lost or changed an item during a stall");

endmodule

/* sv/rrv_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrv_regs
// APB-style configuration register file holding the rectangle geometry.
// ----------------------------------------------------------------------------
module rrv_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rrv_pkg::PADDR_W-1:0]  paddr,
	input  logic [rrv_pkg::PDATA_W-1:0]  pwdata,
	output logic [rrv_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output rrv_pkg::cfg_t                cfg
);

	rrv_pkg::cfg_t     cfg_q;
	rrv_pkg::reg_addr_t addr;
	logic              wr_en;

	assign addr   = rrv_pkg::reg_addr_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= rrv_pkg::RESET_WIDTH;
			cfg_q.height <= rrv_pkg::RESET_HEIGHT;
			cfg_q.radius <= rrv_pkg::RESET_RADIUS;
			cfg_q.points <= rrv_pkg::RESET_POINTS;
		end else if (wr_en) begin
			case (addr)
				rrv_pkg::REG_WIDTH:  cfg_q.width  <= pwdata[rrv_pkg::COORD_W-1:0];
				rrv_pkg::REG_HEIGHT: cfg_q.height <= pwdata[rrv_pkg::COORD_W-1:0];
				rrv_pkg::REG_RADIUS: cfg_q.radius <= pwdata[rrv_pkg::RAD_W-1:0];
				rrv_pkg::REG_POINTS: cfg_q.points <= pwdata[rrv_pkg::PTS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (addr)
			rrv_pkg::REG_WIDTH:  prdata = rrv_pkg::PDATA_W'(cfg_q.width);
			rrv_pkg::REG_HEIGHT: prdata = rrv_pkg::PDATA_W'(cfg_q.height);
			rrv_pkg::REG_RADIUS: prdata = rrv_pkg::PDATA_W'(cfg_q.radius);
			rrv_pkg::REG_POINTS: prdata = rrv_pkg::PDATA_W'(cfg_q.points);
			default:             prdata = '0;
		endcase
	end

endmodule

/* sv/rrv_sin_rom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrv_sin_rom
// Constant sine table: entry [m][k] is sin(k/m of a quarter turn) in Q0.15,
// evaluated at elaboration with a truncated seven-term Taylor series in Q2.30.
// ----------------------------------------------------------------------------
module rrv_sin_rom (
	input  logic [rrv_pkg::ARC_W-1:0]  m,
	input  logic [rrv_pkg::ARC_W-1:0]  ka,
	input  logic [rrv_pkg::ARC_W-1:0]  kb,
	output logic [rrv_pkg::TRIG_W-1:0] sin_a,
	output logic [rrv_pkg::TRIG_W-1:0] sin_b
);

	logic [rrv_pkg::TRIG_W-1:0] rom [rrv_pkg::MAX_CORNER_POINTS][rrv_pkg::MAX_CORNER_POINTS];

	for (genvar gm = 0; gm < rrv_pkg::MAX_CORNER_POINTS; gm++) begin : g_m
		for (genvar gk = 0; gk < rrv_pkg::MAX_CORNER_POINTS; gk++) begin : g_k
			if (gm >= 1 && gk <= gm) begin : g_val
				localparam logic [63:0] MM = 64'(gm);
				localparam logic [63:0] KK = 64'(gk);
				localparam logic [63:0] X  = (rrv_pkg::HALF_PI_Q30 * KK + (MM >> 1)) / MM;
				localparam logic [63:0] X2 = (X * X) >> 30;
				// Each term is the previous one times x^2 / ((2n)(2n+1)).
				localparam logic [63:0] T1 = ((X  * X2) >> 30) / 64'd6;
				localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
				localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
				localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
				localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
				localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
				localparam logic [63:0] POS = X + T2 + T4 + T6;
				localparam logic [63:0] NEG = T1 + T3 + T5;
				localparam logic [63:0] S   = (POS >= NEG) ? (POS - NEG) : 64'd0;
				localparam logic [63:0] Q   = (S + 64'd16384) >> 15;
				localparam logic [63:0] V   = (Q > rrv_pkg::TRIG_SAT) ? rrv_pkg::TRIG_SAT : Q;
				assign rom[gm][gk] = V[rrv_pkg::TRIG_W-1:0];
			end else begin : g_zero
				assign rom[gm][gk] = '0;
			end
		end
	end

	assign sin_a = rom[m][ka];
	assign sin_b = rom[m][kb];

endmodule

/* sv/rrv_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrv_decode
// Clamps radius and point count and splits a vertex index into corner and
// arc position.
// ----------------------------------------------------------------------------
module rrv_decode (
	input  rrv_pkg::cfg_t               cfg,
	input  logic [rrv_pkg::IDX_W-1:0]   point_index,
	output logic [rrv_pkg::COORD_W-1:0] radius,
	output logic [rrv_pkg::ARC_W-1:0]   arc_last,
	output logic [rrv_pkg::ARC_W-1:0]   arc_pos,
	output logic [1:0]                  corner,
	output logic                        sharp,
	output logic                        in_range,
	output logic                        is_final
);

	logic [rrv_pkg::COORD_W-1:0] half_w;
	logic [rrv_pkg::COORD_W-1:0] half_h;
	logic [rrv_pkg::COORD_W-1:0] r_w;
	logic [rrv_pkg::PTS_W-1:0]   n;
	logic [rrv_pkg::COUNT_W-1:0] n1;
	logic [rrv_pkg::COUNT_W-1:0] n2;
	logic [rrv_pkg::COUNT_W-1:0] n3;
	logic [rrv_pkg::COUNT_W-1:0] idx;
	logic [rrv_pkg::COUNT_W-1:0] base;
	logic [rrv_pkg::COUNT_W-1:0] rel;
	logic [rrv_pkg::COUNT_W-1:0] count;
	logic [1:0]                  arc_corner;

	assign half_w = cfg.width >> 1;
	assign half_h = cfg.height >> 1;

	always_comb begin
		if (cfg.radius[rrv_pkg::RAD_W-1]) begin
			r_w = '0;
		end else begin
			r_w = cfg.radius[rrv_pkg::COORD_W-1:0];
		end
		if (r_w > half_w) begin
			r_w = half_w;
		end
		if (r_w > half_h) begin
			r_w = half_h;
		end
	end

	assign radius = r_w;
	assign sharp  = (r_w == '0);

	always_comb begin
		if (cfg.points < rrv_pkg::PTS_W'(2)) begin
			n = rrv_pkg::PTS_W'(2);
		end else if (cfg.points > rrv_pkg::PTS_W'(rrv_pkg::MAX_CORNER_POINTS)) begin
			n = rrv_pkg::PTS_W'(rrv_pkg::MAX_CORNER_POINTS);
		end else begin
			n = cfg.points;
		end
	end

	assign n1  = rrv_pkg::COUNT_W'(n);
	assign n2  = n1 << 1;
	assign n3  = n2 + n1;
	assign idx = rrv_pkg::COUNT_W'(point_index);

	// Index / points per corner is at most three in range; three compares do it.
	always_comb begin
		if (idx >= n3) begin
			arc_corner = 2'd3;
			base       = n3;
		end else if (idx >= n2) begin
			arc_corner = 2'd2;
			base       = n2;
		end else if (idx >= n1) begin
			arc_corner = 2'd1;
			base       = n1;
		end else begin
			arc_corner = 2'd0;
			base       = '0;
		end
	end

	assign rel      = idx - base;
	assign arc_pos  = rel[rrv_pkg::ARC_W-1:0];
	assign arc_last = rrv_pkg::ARC_W'(n - rrv_pkg::PTS_W'(1));
	assign corner   = sharp ? point_index[1:0] : arc_corner;
	assign count    = sharp ? rrv_pkg::COUNT_W'(4) : (n1 << 2);
	assign in_range = idx < count;
	assign is_final = (idx + rrv_pkg::COUNT_W'(1)) == count;

endmodule
